FILE: rtl/differential_drive_odometry_core_defines.svh
// assertion macros for the odometry core
// used by ddo_ctrl and ddo_datapath
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("odometry assertion failed");

// next-cycle implication
`define DDO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

`endif

FILE: rtl/ddo_pkg.sv
// shared types, constants and the cordic angle table for the odometry core
// no dependencies
package ddo_pkg;

    localparam int TRIG_W     = 34;
    localparam int ZW         = 34;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TW_W       = 16;
    localparam int IMU_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_BASE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_IMU    = 1'b1;

    localparam logic [TW_W-1:0]          TW_RESET        = 16'd1024;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]              RAD_TO_TURN     = 31'd683565276;
    localparam logic signed [ZW-1:0]     QUARTER_TURN    = 34'sd1073741824;
    localparam logic signed [ZW-1:0]     HALF_TURN       = 34'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic cordic_en;
        logic mul_en;
        logic div_load;
        logic div_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic mul_last;
        logic div_last;
        logic out_busy;
    } sts_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/differential_drive_odometry_core.sv
// odometry core: one pose per wheel sample, one item in flight at a time
// each item runs through the cordic loop, the bit-serial multipliers over
// POS_BITS+2 bits and the restoring divider over POS_BITS+31 bits
// the next sample is accepted only after the previous one has finished,
// and a pose is written out only while the output register is free
// synchronous active-low reset clears pose, previous positions and control state
module differential_drive_odometry_core #(
    parameter int POS_BITS     = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [ddo_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_position, right_position, imu_heading
    input  logic [((2*POS_BITS+16+7)/8)*8-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pose_x, pose_y, pose_heading
    output logic [((2*POS_BITS+ANGLE_BITS+7)/8)*8-1:0] m_tdata
);
    import ddo_pkg::*;

    localparam int SDW = ((2*POS_BITS+16+7)/8)*8;
    localparam int MDW = ((2*POS_BITS+ANGLE_BITS+7)/8)*8;

    cmd_t cmd;
    sts_t sts;

    ddo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddo_datapath #(
        .POS_BITS     (POS_BITS),
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .SDW          (SDW),
        .MDW          (MDW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: rtl/ddo_ctrl.sv
// sequencing state machine for the odometry core
// depends on ddo_pkg and the assertion macro header
`include "differential_drive_odometry_core_defines.svh"

module ddo_ctrl (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ddo_pkg::sts_t sts,
    output ddo_pkg::cmd_t cmd
);
    import ddo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_CORDIC;
            ST_CORDIC:   if (sts.cordic_last) state_next = ST_MUL;
            ST_MUL:      if (sts.mul_last) state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV:      if (sts.div_last) state_next = ST_FIN;
            ST_FIN:      if (!sts.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_CORDIC:   cmd.cordic_en = 1'b1;
            ST_MUL:      cmd.mul_en    = 1'b1;
            ST_DIV_LOAD: cmd.div_load  = 1'b1;
            ST_DIV:      cmd.div_en    = 1'b1;
            ST_FIN:      cmd.finish    = !sts.out_busy;
            default:     cmd = '0;
        endcase
    end

    `DDO_ASSERT_IMP(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd))
    `DDO_ASSERT_NXT(a_start_cordic, aclk, aresetn, cmd.start, state_reg == ST_CORDIC)
    `DDO_ASSERT_NXT(a_finish_idle, aclk, aresetn, cmd.finish, s_tready)

endmodule

FILE: rtl/ddo_datapath.sv
// cordic, serial multipliers, restoring divider and pose registers
// depends on ddo_pkg and the assertion macro header
`include "differential_drive_odometry_core_defines.svh"

module ddo_datapath #(
    parameter int POS_BITS     = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int SDW          = 80,
    parameter int MDW          = 80
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [ddo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [SDW-1:0]                  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [MDW-1:0]                  m_tdata,
    input  ddo_pkg::cmd_t                   cmd,
    output ddo_pkg::sts_t                   sts
);
    import ddo_pkg::*;

    localparam int PB   = POS_BITS;
    localparam int AB   = ANGLE_BITS;
    localparam int SW   = PB + 2;
    localparam int PW   = TRIG_W + SW;
    localparam int CW   = 31;
    localparam int PDW  = SW + CW;
    localparam int PM   = SW + 29;
    localparam int CNTW = $clog2(PM + 1);
    localparam int EW   = PB + 6;
    localparam int IW   = PW - 31;
    localparam int SHL  = (AB >= IMU_W) ? AB - IMU_W : 0;
    localparam int SHR  = (AB >= IMU_W) ? 0 : IMU_W - AB;

    localparam logic signed [EW-1:0] PMAX = {{(EW-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [EW-1:0] PMIN = ~PMAX;
    localparam logic signed [PW-1:0] RND_TRIG = PW'(64'd1 << 30);
    localparam logic [31:0]          RND_HEAD = 32'(64'd1 << (31 - AB));

    logic [TW_W-1:0]          wheel_base_reg;
    logic                     use_imu_reg;
    logic signed [PB-1:0]     last_left_reg, last_right_reg;
    logic signed [PB-1:0]     acc_x_reg, acc_y_reg;
    logic [AB-1:0]            heading_reg;
    logic [IMU_W-1:0]         imu_reg;
    logic [SW-1:0]            sum_mr_reg, diff_mr_reg;
    logic signed [TRIG_W-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0]     cz_reg;
    logic                     flip_reg;
    logic signed [PW-1:0]     px_reg, py_reg;
    logic signed [PDW-1:0]    pd_reg;
    logic                     neg_reg;
    logic [PM-1:0]            dvd_reg;
    logic [TW_W-1:0]          rem_reg;
    logic [31:0]              quo_reg;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic                     m_valid_reg;
    logic [MDW-1:0]           m_data_reg;

    logic signed [PB-1:0]     lp, rp;
    logic signed [SW-1:0]     dl, dr, sum_w, diff_w;
    logic [31:0]              turn32;
    logic signed [ZW-1:0]     z0;
    logic                     fold;
    logic signed [TRIG_W-1:0] dx, dy, tx, ty;
    logic signed [ZW-1:0]     at;
    logic                     first;
    logic signed [PW-1:0]     addx, addy;
    logic signed [PDW-1:0]    addd, pd_abs;
    logic [TW_W-1:0]          tw_eff;
    logic [TW_W:0]            trial, trial_sub;
    logic                     qbit;
    logic signed [PW-1:0]     rx, ry;
    logic signed [IW-1:0]     inc_x, inc_y;
    logic signed [EW-1:0]     sx, sy, satx, saty;
    logic [31:0]              tq, th;
    logic [AB-1:0]            dh, imu_scaled, heading_new;
    logic [IMU_W+SHL-1:0]     imu_wide;

    // item fields and wheel deltas
    assign lp     = s_tdata[PB-1:0];
    assign rp     = s_tdata[2*PB-1:PB];
    assign dl     = SW'(lp) - SW'(last_left_reg);
    assign dr     = SW'(rp) - SW'(last_right_reg);
    assign sum_w  = dl + dr;
    assign diff_w = dl - dr;

    // cordic start angle with half-turn fold
    assign turn32 = {heading_reg, {(32-AB){1'b0}}};
    assign z0     = ZW'($signed(turn32));
    assign fold   = (z0 > QUARTER_TURN) || (z0 < -QUARTER_TURN);

    assign dx = cy_reg >>> cnt_reg;
    assign dy = cx_reg >>> cnt_reg;
    assign at = ZW'(atan_turn(cnt_reg[4:0]));

    // serial multipliers, msb first, sign bit weighted negative
    assign first = (cnt_reg == '0);
    assign tx    = flip_reg ? -cx_reg : cx_reg;
    assign ty    = flip_reg ? -cy_reg : cy_reg;
    assign addx  = sum_mr_reg[SW-1] ? (first ? -PW'(tx) : PW'(tx)) : '0;
    assign addy  = sum_mr_reg[SW-1] ? (first ? -PW'(ty) : PW'(ty)) : '0;
    assign addd  = diff_mr_reg[SW-1]
                 ? (first ? -$signed(PDW'(RAD_TO_TURN)) : $signed(PDW'(RAD_TO_TURN))) : '0;

    // restoring divider
    assign pd_abs    = pd_reg[PDW-1] ? -pd_reg : pd_reg;
    assign tw_eff    = (wheel_base_reg == '0) ? TW_W'(1) : wheel_base_reg;
    assign trial     = {rem_reg, dvd_reg[PM-1]};
    assign qbit      = (trial >= {1'b0, tw_eff});
    assign trial_sub = trial - {1'b0, tw_eff};

    // pose update
    assign rx    = px_reg + RND_TRIG;
    assign ry    = py_reg + RND_TRIG;
    assign inc_x = rx[PW-1:31];
    assign inc_y = ry[PW-1:31];
    assign sx    = EW'(acc_x_reg) + EW'(inc_x);
    assign sy    = EW'(acc_y_reg) + EW'(inc_y);
    assign satx  = (sx > PMAX) ? PMAX : ((sx < PMIN) ? PMIN : sx);
    assign saty  = (sy > PMAX) ? PMAX : ((sy < PMIN) ? PMIN : sy);

    assign tq          = neg_reg ? -(quo_reg + 32'(rem_reg != '0)) : quo_reg;
    assign th          = tq + RND_HEAD;
    assign dh          = th[31:32-AB];
    assign imu_wide    = (IMU_W+SHL)'(imu_reg) << SHL;
    assign imu_scaled  = AB'(imu_wide >> SHR);
    assign heading_new = use_imu_reg ? imu_scaled : heading_reg + dh;

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.start || cmd.div_load) begin
            cnt_next = '0;
        end else if ((cmd.cordic_en && sts.cordic_last) || (cmd.mul_en && sts.mul_last)
                     || (cmd.div_en && sts.div_last)) begin
            cnt_next = '0;
        end else if (cmd.cordic_en || cmd.mul_en || cmd.div_en) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign sts.cordic_last = (cnt_reg == CNTW'(CORDIC_STEPS - 1));
    assign sts.mul_last    = (cnt_reg == CNTW'(SW - 1));
    assign sts.div_last    = (cnt_reg == CNTW'(PM - 1));
    assign sts.out_busy    = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_base_reg  <= TW_RESET;
            use_imu_reg     <= 1'b0;
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            heading_reg     <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_wen) begin
                case (cfg_addr)
                    REG_WHEEL_BASE: wheel_base_reg <= cfg_wdata;
                    REG_USE_IMU:    use_imu_reg    <= cfg_wdata[0];
                    default:        use_imu_reg    <= use_imu_reg;
                endcase
            end
            if (cmd.start) begin
                last_left_reg  <= lp;
                last_right_reg <= rp;
            end
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                acc_x_reg   <= satx[PB-1:0];
                acc_y_reg   <= saty[PB-1:0];
                heading_reg <= heading_new;
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            imu_reg     <= s_tdata[2*PB+IMU_W-1:2*PB];
            sum_mr_reg  <= sum_w;
            diff_mr_reg <= diff_w;
            cx_reg      <= CORDIC_GAIN_Q30;
            cy_reg      <= '0;
            cz_reg      <= fold ? (z0[ZW-1] ? z0 + HALF_TURN : z0 - HALF_TURN) : z0;
            flip_reg    <= fold;
            px_reg      <= '0;
            py_reg      <= '0;
            pd_reg      <= '0;
        end
        if (cmd.cordic_en) begin
            if (!cz_reg[ZW-1]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - at;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.mul_en) begin
            px_reg      <= (px_reg <<< 1) + addx;
            py_reg      <= (py_reg <<< 1) + addy;
            pd_reg      <= (pd_reg <<< 1) + addd;
            sum_mr_reg  <= sum_mr_reg << 1;
            diff_mr_reg <= diff_mr_reg << 1;
        end
        if (cmd.div_load) begin
            neg_reg <= pd_reg[PDW-1];
            dvd_reg <= pd_abs[PM-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div_en) begin
            rem_reg <= qbit ? trial_sub[TW_W-1:0] : trial[TW_W-1:0];
            quo_reg <= {quo_reg[30:0], qbit};
            dvd_reg <= dvd_reg << 1;
        end
        if (cmd.finish) begin
            m_data_reg <= MDW'({heading_new, saty[PB-1:0], satx[PB-1:0]});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DDO_ASSERT_NXT(a_start_cnt, aclk, aresetn, cmd.start, cnt_reg == '0)
    `DDO_ASSERT_NXT(a_div_rem, aclk, aresetn, cmd.div_en, rem_reg < tw_eff)
    `DDO_ASSERT_IMP(a_fin_free, aclk, aresetn, cmd.finish, !(m_valid_reg && !m_tready))

endmodule
